FILE: sv/pareto_front_insert_2d_unit_defines.svh
// Assertion macros for the two-objective front keeper.
// No dependencies; expects clk and rst_n in the including module.
`ifndef PARETO_FRONT_INSERT_2D_UNIT_DEFINES_SVH
`define PARETO_FRONT_INSERT_2D_UNIT_DEFINES_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/pfi2d_pkg.sv
// Shared types for the two-objective front keeper.
// No dependencies.
package pfi2d_pkg;

  typedef enum logic [1:0] {
    FOP_HOLD,
    FOP_COMPACT,
    FOP_INSERT
  } front_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L_CHK,
    ST_L_RUN,
    ST_G_CHK,
    ST_G_RUN
  } state_t;

  typedef struct packed {
    logic dom;
    logic full;
    logic any_rm;
  } front_stat_t;

endpackage

FILE: sv/pfi2d_cell.sv
// One front entry: holds (x, y), compares it against the point under test.
// Depends on pfi2d_pkg.
module pfi2d_cell #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic [CW-1:0]          pt_x,
  input  logic [CW-1:0]          pt_y,
  input  logic                   valid,
  input  logic [CW-1:0]          left_x,
  input  logic [CW-1:0]          left_y,
  input  logic                   left_lt,
  input  logic [CW-1:0]          right_x,
  input  logic [CW-1:0]          right_y,
  input  pfi2d_pkg::front_op_t   op,
  output logic [CW-1:0]          x,
  output logic [CW-1:0]          y,
  output logic                   lt,
  output logic                   dom,
  output logic                   rm
);
  import pfi2d_pkg::*;

  logic [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic          ge;

  assign lt  = valid && (x_r < pt_x);
  assign ge  = valid && (pt_x <= x_r);
  assign dom = valid && (x_r <= pt_x) && (y_r <= pt_y);
  assign rm  = ge && (y_r >= pt_y);
  assign x   = x_r;
  assign y   = y_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    case (op)
      FOP_COMPACT: begin
        // everything from the insertion place onward moves down one
        if (ge || !valid) begin
          x_nxt = right_x;
          y_nxt = right_y;
        end
      end
      FOP_INSERT: begin
        if (!lt) begin
          if (left_lt) begin
            x_nxt = pt_x;
            y_nxt = pt_y;
          end else begin
            x_nxt = left_x;
            y_nxt = left_y;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

endmodule

FILE: sv/pfi2d_row.sv
// One front: a row of entry cells plus its fill count.
// Depends on pfi2d_pkg, pfi2d_cell and the assertion header.
module pfi2d_row #(
  parameter int DEPTH = 64,
  parameter int CW    = 32,
  parameter int SW    = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CW-1:0]          pt_x,
  input  logic [CW-1:0]          pt_y,
  input  pfi2d_pkg::front_op_t   op,
  input  logic                   clr,
  output pfi2d_pkg::front_stat_t stat,
  output logic [SW-1:0]          size
);
  import pfi2d_pkg::*;
  `include "pareto_front_insert_2d_unit_defines.svh"

  logic [CW-1:0]    x_a [DEPTH];
  logic [CW-1:0]    y_a [DEPTH];
  logic [DEPTH-1:0] lt_a, dom_a, rm_a;
  logic [SW-1:0]    size_r, size_nxt;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [CW-1:0] lx, ly, rx, ry;
      logic          llt;
      if (i == 0) begin : g_first
        assign lx  = '0;
        assign ly  = '0;
        assign llt = 1'b1;
      end else begin : g_mid
        assign lx  = x_a[i-1];
        assign ly  = y_a[i-1];
        assign llt = lt_a[i-1];
      end
      if (i == DEPTH-1) begin : g_last
        assign rx = x_a[i];
        assign ry = y_a[i];
      end else begin : g_inner
        assign rx = x_a[i+1];
        assign ry = y_a[i+1];
      end
      pfi2d_cell #(.CW(CW)) u_cell (
        .clk     (clk),
        .pt_x    (pt_x),
        .pt_y    (pt_y),
        .valid   (SW'(i) < size_r),
        .left_x  (lx),
        .left_y  (ly),
        .left_lt (llt),
        .right_x (rx),
        .right_y (ry),
        .op      (op),
        .x       (x_a[i]),
        .y       (y_a[i]),
        .lt      (lt_a[i]),
        .dom     (dom_a[i]),
        .rm      (rm_a[i])
      );
    end
  endgenerate

  assign stat.dom    = |dom_a;
  assign stat.full   = (size_r == SW'(DEPTH));
  assign stat.any_rm = |rm_a;
  assign size        = size_r;

  always_comb begin
    size_nxt = size_r;
    if (clr) begin
      size_nxt = '0;
    end else begin
      case (op)
        FOP_COMPACT: size_nxt = size_r - SW'(1);
        FOP_INSERT:  size_nxt = size_r + SW'(1);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      size_r <= size_nxt;
    end
  end

  `ASSERT_IMP(a_size_bound, 1'b1, size_r <= SW'(DEPTH))
  `ASSERT_IMP(a_insert_not_full, op == FOP_INSERT, !stat.full)
  `ASSERT_NEXT(a_compact_shrinks, op == FOP_COMPACT && !clr, size_r == $past(size_r) - SW'(1))

endmodule

FILE: sv/pareto_front_insert_2d_unit.sv
// Two-objective front keeper, top level: control sequencer, maxima, two fronts.
// Depends on pfi2d_pkg, pfi2d_row and the assertion header.
//
// A point is taken when start is high and busy low; busy then stays high until the
// result word is shown on the out_ ports for one cycle with out_valid. The receiver
// cannot stall, so each result must be captured in that cycle. A rejected point goes
// from the local check state straight back to idle; a point that enters the local front
// also passes the local run state, and then the global check and run states unless the
// global check rejects it. Each run state drops one covered entry per cycle and then
// inserts the point. A new point may be started in the strobe cycle.
module pareto_front_insert_2d_unit #(
  parameter int FRONT_DEPTH = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic        in_group_start,
  input  logic        in_restart,
  output logic        out_valid,
  output logic        out_local_optimal,
  output logic        out_global_optimal,
  output logic [6:0]  out_local_count,
  output logic [6:0]  out_global_count,
  output logic        out_overflow,
  output logic [31:0] out_max_x,
  output logic [31:0] out_max_y
);
  import pfi2d_pkg::*;
  `include "pareto_front_insert_2d_unit_defines.svh"

  localparam int CW = COORD_WIDTH;
  localparam int SW = $clog2(FRONT_DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] pt_x_r, pt_x_nxt, pt_y_r, pt_y_nxt;
  logic [CW-1:0] max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  logic [CW-1:0] px, py, mx, my;
  logic          loc_r, loc_nxt, glob_r, glob_nxt, ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  front_op_t     lop, gop;
  logic          lclr, gclr;
  front_stat_t   lstat, gstat;
  logic [SW-1:0] lsize, gsize;

  assign px = in_point_x[CW-1:0];
  assign py = in_point_y[CW-1:0];

  pfi2d_row #(.DEPTH(FRONT_DEPTH), .CW(CW), .SW(SW)) u_local (
    .clk   (clk),
    .rst_n (rst_n),
    .pt_x  (pt_x_r),
    .pt_y  (pt_y_r),
    .op    (lop),
    .clr   (lclr),
    .stat  (lstat),
    .size  (lsize)
  );

  pfi2d_row #(.DEPTH(FRONT_DEPTH), .CW(CW), .SW(SW)) u_global (
    .clk   (clk),
    .rst_n (rst_n),
    .pt_x  (pt_x_r),
    .pt_y  (pt_y_r),
    .op    (gop),
    .clr   (gclr),
    .stat  (gstat),
    .size  (gsize)
  );

  always_comb begin
    state_nxt     = state_r;
    pt_x_nxt      = pt_x_r;
    pt_y_nxt      = pt_y_r;
    max_x_nxt     = max_x_r;
    max_y_nxt     = max_y_r;
    loc_nxt       = loc_r;
    glob_nxt      = glob_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    lop           = FOP_HOLD;
    gop           = FOP_HOLD;
    lclr          = 1'b0;
    gclr          = 1'b0;
    mx            = in_restart ? '0 : max_x_r;
    my            = in_restart ? '0 : max_y_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          lclr      = in_group_start || in_restart;
          gclr      = in_restart;
          pt_x_nxt  = px;
          pt_y_nxt  = py;
          max_x_nxt = (px > mx) ? px : mx;
          max_y_nxt = (py > my) ? py : my;
          loc_nxt   = 1'b0;
          glob_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_L_CHK;
        end
      end
      ST_L_CHK: begin
        if (lstat.dom) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (lstat.full) begin
          ovf_nxt       = 1'b1;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_L_RUN;
        end
      end
      ST_L_RUN: begin
        // drop covered entries one per cycle, then insert
        if (lstat.any_rm) begin
          lop = FOP_COMPACT;
        end else begin
          lop       = FOP_INSERT;
          loc_nxt   = 1'b1;
          state_nxt = ST_G_CHK;
        end
      end
      ST_G_CHK: begin
        if (gstat.dom) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (gstat.full) begin
          ovf_nxt       = 1'b1;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_G_RUN;
        end
      end
      ST_G_RUN: begin
        if (gstat.any_rm) begin
          gop = FOP_COMPACT;
        end else begin
          gop           = FOP_INSERT;
          glob_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_x_r     <= '0;
      max_y_r     <= '0;
      out_valid_r <= 1'b0;
      loc_r       <= 1'b0;
      glob_r      <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_x_r     <= max_x_nxt;
      max_y_r     <= max_y_nxt;
      out_valid_r <= out_valid_nxt;
      loc_r       <= loc_nxt;
      glob_r      <= glob_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_x_r <= pt_x_nxt;
    pt_y_r <= pt_y_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_local_optimal  = loc_r;
  assign out_global_optimal = glob_r;
  assign out_overflow       = ovf_r;
  assign out_local_count    = 7'(lsize);
  assign out_global_count   = 7'(gsize);
  assign out_max_x          = 32'(max_x_r);
  assign out_max_y          = 32'(max_y_r);

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_IMP(a_glob_needs_loc, out_valid && out_global_optimal, out_local_optimal)
  `ASSERT_IMP(a_glob_no_ovf, out_valid && out_global_optimal, !out_overflow)
  `ASSERT_IMP(a_strobe_idle, out_valid, !busy)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pareto_front_insert_2d_unit: directed table, a front fill with overflow, then random points.
// Depends on the RTL top level only; predicts each result word with its own front model.
module tb_top;
  localparam int DEPTH = 64;
  localparam int N_RAND = 420;

  typedef struct packed {
    logic        loc;
    logic        glob;
    logic [6:0]  lcnt;
    logic [6:0]  gcnt;
    logic        ovf;
    logic [31:0] mx;
    logic [31:0] my;
  } res_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        grp;
    logic        rst;
    logic        has_exp;
    res_t        exp_res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_point_x = '0;
  logic [31:0] in_point_y = '0;
  logic in_group_start = 1'b0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_local_optimal, out_global_optimal, out_overflow;
  logic [6:0] out_local_count, out_global_count;
  logic [31:0] out_max_x, out_max_y;

  pareto_front_insert_2d_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] lf_x[DEPTH], lf_y[DEPTH], gf_x[DEPTH], gf_y[DEPTH];
  int unsigned lf_n, gf_n;
  logic [31:0] run_mx, run_my;

  res_t pending_words[$];
  int errors = 0;
  int n_words = 0, n_loc = 0, n_glob = 0, n_ovf = 0;

  function automatic bit front_insert(ref logic [31:0] fx[DEPTH], ref logic [31:0] fy[DEPTH],
                                      ref int unsigned n, input logic [31:0] x,
                                      input logic [31:0] y, ref bit ovf);
    int unsigned pos;
    int unsigned w;
    logic [31:0] tx[DEPTH], ty[DEPTH];
    int unsigned tn;
    pos = 0;
    tn = 0;
    while (pos < n) begin
      if (x >= fx[pos] && y >= fy[pos]) return 0;
      if (x <= fx[pos]) break;
      pos++;
    end
    if (n >= DEPTH) begin
      ovf = 1;
      return 0;
    end
    for (int k = pos; k < n; k++)
      if (fy[k] < y) begin
        tx[tn] = fx[k];
        ty[tn] = fy[k];
        tn++;
      end
    fx[pos] = x;
    fy[pos] = y;
    w = pos + 1;
    for (int k = 0; k < tn && w < DEPTH; k++) begin
      fx[w] = tx[k];
      fy[w] = ty[k];
      w++;
    end
    n = w;
    return 1;
  endfunction

  function automatic res_t predict_front(logic [31:0] x, logic [31:0] y, logic grp, logic rst);
    res_t r;
    bit ovf;
    bit loc;
    bit glob;
    ovf = 0;
    glob = 0;
    if (rst) begin
      lf_n = 0;
      gf_n = 0;
      run_mx = '0;
      run_my = '0;
    end
    if (grp) lf_n = 0;
    if (x > run_mx) run_mx = x;
    if (y > run_my) run_my = y;
    loc = front_insert(lf_x, lf_y, lf_n, x, y, ovf);
    if (loc) glob = front_insert(gf_x, gf_y, gf_n, x, y, ovf);
    r.loc = loc;
    r.glob = glob;
    r.lcnt = lf_n[6:0];
    r.gcnt = gf_n[6:0];
    r.ovf = ovf;
    r.mx = run_mx;
    r.my = run_my;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch word %0d %s: got %0h want %0h", n_words, what, got, want);
  endtask

  // result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      res_t e;
      if (pending_words.size() == 0) begin
        errors++;
        $display("unexpected result word at %0t", $time);
      end else begin
        e = pending_words.pop_front();
        if (out_local_optimal !== e.loc) report_mismatch("local_optimal", out_local_optimal, e.loc);
        if (out_global_optimal !== e.glob)
          report_mismatch("global_optimal", out_global_optimal, e.glob);
        if (out_local_count !== e.lcnt) report_mismatch("local_count", out_local_count, e.lcnt);
        if (out_global_count !== e.gcnt)
          report_mismatch("global_count", out_global_count, e.gcnt);
        if (out_overflow !== e.ovf) report_mismatch("overflow", out_overflow, e.ovf);
        if (out_max_x !== e.mx) report_mismatch("max_x", out_max_x, e.mx);
        if (out_max_y !== e.my) report_mismatch("max_y", out_max_y, e.my);
        n_loc += e.loc;
        n_glob += e.glob;
        n_ovf += e.ovf;
      end
      n_words++;
    end
  end

  // drive one point at the falling edge, hold until accepted
  task automatic send_point(row_t r, int idle_pct);
    res_t p;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_point_x = r.x;
    in_point_y = r.y;
    in_group_start = r.grp;
    in_restart = r.rst;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_front(r.x, r.y, r.grp, r.rst);
    if (r.has_exp && p !== r.exp_res) begin
      errors++;
      $display("directed row disagrees with predictor at x=%0h y=%0h", r.x, r.y);
    end
    pending_words.push_back(p);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic row_t mk(logic [31:0] x, logic [31:0] y, logic g, logic rs);
    row_t r;
    r.x = x;
    r.y = y;
    r.grp = g;
    r.rst = rs;
    r.has_exp = 0;
    r.exp_res = '0;
    return r;
  endfunction

  function automatic row_t mke(logic [31:0] x, logic [31:0] y, logic g, logic rs, res_t e);
    row_t r;
    r = mk(x, y, g, rs);
    r.has_exp = 1;
    r.exp_res = e;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    row_t dir[$];
    row_t r;
    int grp_len;
    int base;
    int idle;
    lf_n = 0;
    gf_n = 0;
    run_mx = '0;
    run_my = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: first point, extremes, equal point, both flags, removals
    dir.push_back(mke(32'd100, 32'd100, 0, 0, '{1, 1, 7'd1, 7'd1, 0, 32'd100, 32'd100}));
    dir.push_back(mke(32'd100, 32'd100, 0, 0, '{0, 0, 7'd1, 7'd1, 0, 32'd100, 32'd100}));
    dir.push_back(mk(32'd200, 32'd50, 0, 0));
    dir.push_back(mk(32'd50, 32'd200, 0, 0));
    dir.push_back(mk(32'd10, 32'd10, 0, 0));
    dir.push_back(mk(32'hFFFFFFFF, 32'h0, 0, 0));
    dir.push_back(mk(32'h0, 32'hFFFFFFFF, 0, 0));
    dir.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
    dir.push_back(mk(32'd500, 32'd5, 1, 0));
    dir.push_back(mk(32'd600, 32'd600, 1, 0));
    dir.push_back(mke(32'h0, 32'h0, 1, 1, '{1, 1, 7'd1, 7'd1, 0, 32'h0, 32'h0}));
    dir.push_back(mke(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1,
                      '{1, 1, 7'd1, 7'd1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF}));
    dir.push_back(mk(32'hAAAAAAAA, 32'h55555555, 0, 1));
    dir.push_back(mk(32'h55555555, 32'hAAAAAAAA, 0, 0));
    dir.push_back(mk(32'h1, 32'h1, 1, 0));
    foreach (dir[i]) send_point(dir[i], 21);

    // fill the local front to its depth, then force overflow on both
    r = mk(0, 0, 0, 1);
    for (int k = 0; k < DEPTH; k++) begin
      r.x = 32'(k * 16 + 16);
      r.y = 32'((DEPTH - k) * 16 + 16);
      send_point(r, 0);
      r.rst = 0;
    end
    send_point(mk(32'd8, 32'd4000, 0, 0), 0);
    send_point(mk(32'd20, 32'd1, 1, 0), 0);
    send_point(mk(32'd1, 32'd1, 0, 0), 0);
    // sender holds off until every result has come
    wait_drained();

    // random: groups of points with coordinates in 0..4000, with noise
    base = 0;
    for (int i = 0; i < N_RAND; i += grp_len) begin
      grp_len = $urandom_range(4, 24);
      idle = (i > 150 && i < 260) ? 0 : 21;
      for (int k = 0; k < grp_len; k++) begin
        r = mk($urandom_range(0, 4000), $urandom_range(0, 4000), k == 0,
               (k == 0) && ($urandom_range(9) == 0));
        case ($urandom_range(9))
          0: r.x = $urandom();
          1: r.y = $urandom();
          2: begin
            r.x = $urandom();
            r.y = $urandom();
          end
          3: r.x = {1'($urandom_range(1)), 31'($urandom_range(3))};
          4: r.y = {1'($urandom_range(1)), 31'($urandom_range(3))};
          default: ;
        endcase
        if (k != 0 && $urandom_range(19) == 0) r.grp = 1;
        send_point(r, idle);
        if ($urandom_range(99) == 0) wait_drained();
      end
    end
    wait_drained();
    repeat (200) @(negedge clk);
    $display("covered %0d result words: %0d local entries, %0d global entries, %0d overflows",
             n_words, n_loc, n_glob, n_ovf);
    $display("directed extremes, equal points, group starts, restarts, full fronts");
    if (errors == 0)
      $display("PASS pareto_front_insert_2d_unit");
    else
      $display("FAIL pareto_front_insert_2d_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL pareto_front_insert_2d_unit");
    $finish;
  end
endmodule
